// ===== sv/idp_pkg.sv =====
package idp_pkg;

    localparam logic [31:0] CANON_NAN   = 32'h7FC0_0000;
    localparam logic [3:0]  NIBBLE_MASK = 4'hF;

    // One queued term: operands ready for the arithmetic back end
    typedef struct packed {
        logic [31:0] act;
        logic [31:0] wgt;
        logic [31:0] scale;
        logic        last;
    } t_term;

    typedef enum logic [1:0] {
        B_IDLE,
        B_MUL1,
        B_MUL2,
        B_ADD
    } t_bstate;

    // Signed 4-bit weight to IEEE single
    function automatic logic [31:0] nib_to_fp(input logic [3:0] nib);
        logic [31:0] r;
        case (nib)
            4'h0: r = 32'h0000_0000;
            4'h1: r = 32'h3F80_0000;
            4'h2: r = 32'h4000_0000;
            4'h3: r = 32'h4040_0000;
            4'h4: r = 32'h4080_0000;
            4'h5: r = 32'h40A0_0000;
            4'h6: r = 32'h40C0_0000;
            4'h7: r = 32'h40E0_0000;
            4'h8: r = 32'hC100_0000;
            4'h9: r = 32'hC0E0_0000;
            4'hA: r = 32'hC0C0_0000;
            4'hB: r = 32'hC0A0_0000;
            4'hC: r = 32'hC080_0000;
            4'hD: r = 32'hC040_0000;
            4'hE: r = 32'hC000_0000;
            default: r = 32'hBF80_0000;
        endcase
        return r;
    endfunction

    function automatic logic [5:0] clz48(input logic [47:0] v);
        logic [5:0] cnt;
        logic       found;
        cnt   = '0;
        found = 1'b0;
        for (int i = 47; i >= 0; i--) begin
            if (!found) begin
                if (v[i]) found = 1'b1;
                else      cnt = cnt + 6'd1;
            end
        end
        return cnt;
    endfunction

    function automatic logic [4:0] clz28(input logic [27:0] v);
        logic [4:0] cnt;
        logic       found;
        cnt   = '0;
        found = 1'b0;
        for (int i = 27; i >= 0; i--) begin
            if (!found) begin
                if (v[i]) found = 1'b1;
                else      cnt = cnt + 5'd1;
            end
        end
        return cnt;
    endfunction

    // IEEE single multiply, round to nearest even, subnormals kept
    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        logic               s, a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
        logic [23:0]        ma, mb;
        logic signed [11:0] ea, eb, e, sh;
        logic [47:0]        p, n, n2;
        logic [5:0]         lz;
        logic [7:0]         ef;
        logic [22:0]        frac;
        logic               g, st, lost, rup;
        logic [30:0]        res;
        logic [31:0]        r;
        s      = a[31] ^ b[31];
        a_nan  = (&a[30:23]) && (|a[22:0]);
        b_nan  = (&b[30:23]) && (|b[22:0]);
        a_inf  = (&a[30:23]) && !(|a[22:0]);
        b_inf  = (&b[30:23]) && !(|b[22:0]);
        a_zero = (a[30:0] == 31'd0);
        b_zero = (b[30:0] == 31'd0);
        ma = {|a[30:23], a[22:0]};
        mb = {|b[30:23], b[22:0]};
        ea = (a[30:23] == 8'd0) ? 12'sd1 : $signed({4'd0, a[30:23]});
        eb = (b[30:23] == 8'd0) ? 12'sd1 : $signed({4'd0, b[30:23]});
        p  = ma * mb;
        lz = clz48(p);
        n  = p << lz;
        e  = ea + eb - 12'sd126 - $signed({6'd0, lz});
        sh = 12'sd1 - e;
        ef = 8'd0; frac = '0; g = 1'b0; st = 1'b0; lost = 1'b0; n2 = '0;
        if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
            r = CANON_NAN;
        end else if (a_inf || b_inf) begin
            r = {s, 8'hFF, 23'd0};
        end else if (a_zero || b_zero) begin
            r = {s, 31'd0};
        end else if (e >= 12'sd255) begin
            r = {s, 8'hFF, 23'd0};
        end else begin
            if (e >= 12'sd1) begin
                ef   = e[7:0];
                frac = n[46:24];
                g    = n[23];
                st   = |n[22:0];
            end else begin
                // Denormalize: shift right, keep what falls off as sticky
                if (sh >= 12'sd48) begin
                    n2   = '0;
                    lost = |n;
                end else begin
                    n2   = n >> sh[5:0];
                    lost = |(n & ((48'd1 << sh[5:0]) - 48'd1));
                end
                frac = n2[46:24];
                g    = n2[23];
                st   = (|n2[22:0]) | lost;
            end
            rup = g & (st | frac[0]);
            res = {ef, frac} + {30'd0, rup};
            r   = {s, res};
        end
        return r;
    endfunction

    // IEEE single add, round to nearest even, subnormals kept
    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
        logic        a_nan, b_nan, a_inf, b_inf;
        logic [31:0] x, y, r;
        logic [23:0] mx, my;
        logic [7:0]  ex, ey, d;
        logic [26:0] xa, yb, yal;
        logic [27:0] sum, n;
        logic [4:0]  lz, shl;
        logic [8:0]  e;
        logic [7:0]  ef;
        logic [22:0] frac;
        logic        g, st, rup;
        logic [30:0] res;
        a_nan = (&a[30:23]) && (|a[22:0]);
        b_nan = (&b[30:23]) && (|b[22:0]);
        a_inf = (&a[30:23]) && !(|a[22:0]);
        b_inf = (&b[30:23]) && !(|b[22:0]);
        if (a[30:0] < b[30:0]) begin
            x = b; y = a;
        end else begin
            x = a; y = b;
        end
        mx = {|x[30:23], x[22:0]};
        my = {|y[30:23], y[22:0]};
        ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
        ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
        d  = ex - ey;
        xa = {mx, 3'b000};
        yb = {my, 3'b000};
        if (d >= 8'd27) begin
            yal = {26'd0, |my};
        end else begin
            yal = yb >> d[4:0];
            yal[0] = yal[0] | (|(yb & ((27'd1 << d[4:0]) - 27'd1)));
        end
        if (x[31] ^ y[31]) sum = {1'b0, xa} - {1'b0, yal};
        else               sum = {1'b0, xa} + {1'b0, yal};
        lz  = clz28(sum);
        shl = ({3'd0, lz} > ex) ? ex[4:0] : lz;
        n   = sum << shl;
        e   = {1'b0, ex} + 9'd1 - {4'd0, shl};
        ef  = n[27] ? e[7:0] : 8'd0;
        frac = n[26:4];
        g    = n[3];
        st   = |n[2:0];
        rup  = g & (st | frac[0]);
        res  = {ef, frac} + {30'd0, rup};
        if (a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31]))) begin
            r = CANON_NAN;
        end else if (a_inf) begin
            r = a;
        end else if (b_inf) begin
            r = b;
        end else if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) begin
            r = {a[31] & b[31], 31'd0};
        end else if (sum == 28'd0) begin
            r = 32'd0;
        end else if (n[27] && (e >= 9'd255)) begin
            r = {x[31], 8'hFF, 23'd0};
        end else begin
            r = {x[31], res};
        end
        return r;
    endfunction

endpackage

// ===== sv/idp_front.sv =====
module idp_front
    import idp_pkg::*;
(
    input  logic        i_valid,
    input  logic [31:0] i_activation,
    input  logic [7:0]  i_weight_byte,
    input  logic        i_high_nibble,
    input  logic [31:0] i_group_scale,
    input  logic        i_last_term,
    input  logic        i_q_full,
    output logic        o_ready,
    output logic        o_push,
    output t_term       o_term
);

    logic [3:0] nib;

    // Pick the nibble and turn it into a float
    assign nib = i_high_nibble ? (i_weight_byte[7:4] & NIBBLE_MASK)
                               : (i_weight_byte[3:0] & NIBBLE_MASK);

    assign o_ready      = !i_q_full;
    assign o_push       = i_valid && !i_q_full;
    assign o_term.act   = i_activation;
    assign o_term.wgt   = nib_to_fp(nib);
    assign o_term.scale = i_group_scale;
    assign o_term.last  = i_last_term;

endmodule

// ===== sv/idp_queue.sv =====
module idp_queue
    import idp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_term i_term,
    input  logic  i_pop,
    output t_term o_term,
    output logic  o_full,
    output logic  o_empty
);

    t_term      r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    // Two-entry queue
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_term;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    assign o_term  = r_mem[r_rp];
    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);

endmodule

// ===== sv/idp_back.sv =====
module idp_back
    import idp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_empty,
    input  t_term       i_term,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_dot_sum
);

    t_bstate     r_state, n_state;
    t_term       r_op;
    logic [31:0] r_prod, r_sum, r_out;
    logic        r_out_vld;
    logic        out_busy, add_go;
    logic [31:0] sum_nxt;
    logic [31:0] mul_a, mul_b, mul_res;

    assign out_busy = r_out_vld && !i_ready;
    assign sum_nxt  = fp_add(r_sum, r_prod);

    // One multiplier: activation * weight first, then product * scale
    assign mul_a   = (r_state == B_MUL1) ? r_op.act : r_prod;
    assign mul_b   = (r_state == B_MUL1) ? r_op.wgt : r_op.scale;
    assign mul_res = fp_mul(mul_a, mul_b);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: if (!i_q_empty) n_state = B_MUL1;
            B_MUL1: n_state = B_MUL2;
            B_MUL2: n_state = B_ADD;
            B_ADD:  if (add_go) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        o_pop  = 1'b0;
        add_go = 1'b0;
        case (r_state)
            B_IDLE:  o_pop  = !i_q_empty;
            B_ADD:   add_go = !(r_op.last && out_busy);
            default: ;
        endcase
    end

    // Operand and product registers
    always_ff @(posedge i_clk) begin
        if (o_pop) r_op <= i_term;
        if (r_state inside {B_MUL1, B_MUL2}) r_prod <= mul_res;
        if (add_go && r_op.last) r_out <= sum_nxt;
    end

    // State, accumulator and output flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= B_IDLE;
            r_sum     <= 32'd0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (add_go) r_sum <= r_op.last ? 32'd0 : sum_nxt;
            if (add_go && r_op.last) r_out_vld <= 1'b1;
            else if (i_ready)        r_out_vld <= 1'b0;
        end
    end

    assign o_valid   = r_out_vld;
    assign o_dot_sum = r_out;

endmodule

// ===== sv/int4_dequant_dot_product.sv =====
// Channel | handshake          | payload
// in      | i_valid / o_ready  | i_activation, i_weight_byte, i_high_nibble,
//         |                    | i_group_scale, i_last_term
// out     | o_valid / i_ready  | o_dot_sum
//
// In the back end each item goes through the queue pop, two fp32 multiplies
// on one shared multiplier path, then the accumulate add.
// A two-entry queue decouples input acceptance from the arithmetic.
// Synchronous active-low reset clears the sum to +0 and empties the queue.
// A last item stalls in the add step while a previous result is untaken.
module int4_dequant_dot_product
    import idp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_activation,
    input  logic [7:0]  i_weight_byte,
    input  logic        i_high_nibble,
    input  logic [31:0] i_group_scale,
    input  logic        i_last_term,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_dot_sum
);

    t_term front_term, q_term;
    logic  q_push, q_pop, q_full, q_empty;

    idp_front u_front (
        .i_valid       (i_valid),
        .i_activation  (i_activation),
        .i_weight_byte (i_weight_byte),
        .i_high_nibble (i_high_nibble),
        .i_group_scale (i_group_scale),
        .i_last_term   (i_last_term),
        .i_q_full      (q_full),
        .o_ready       (o_ready),
        .o_push        (q_push),
        .o_term        (front_term)
    );

    idp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_term  (front_term),
        .i_pop   (q_pop),
        .o_term  (q_term),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    idp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_term    (q_term),
        .o_pop     (q_pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_dot_sum (o_dot_sum)
    );

    // Queue never overflows or underflows
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_push && q_full)) else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_pop && q_empty)) else $error("queue pop while empty");
    // Reset drops any pending result
    a_rst_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

// ===== tb/tb_int4_dequant_dot_product.sv =====
module tb_int4_dequant_dot_product
    import idp_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // IEEE single helpers: value = m * 2^e, rounded to nearest even
    function automatic logic [31:0] sp_round(input bit s, input logic [127:0] m,
                                             input int e);
        int p, lead, sh, lsb, be;
        logic [127:0] q, rem, half;
        bit up;
        p = 0;
        for (int i = 0; i < 128; i++) if (m[i]) p = i;
        lead = p + e;
        sh = (lead >= -126) ? p - 23 : -149 - e;
        up = 1'b0;
        if (sh > 100) begin
            q = '0;
        end else if (sh > 0) begin
            q    = m >> sh;
            rem  = m & ((128'd1 << sh) - 128'd1);
            half = 128'd1 << (sh - 1);
            up   = (rem > half) || (rem == half && q[0]);
            q    = q + up;
        end else begin
            q = m << (-sh);
        end
        lsb = e + sh;
        if (q[24]) begin
            q = q >> 1;
            lsb++;
        end
        if (q[23]) begin
            be = lsb + 23 + 127;
            if (be >= 255) return {s, 8'hFF, 23'd0};
            return {s, be[7:0], q[22:0]};
        end
        return {s, 8'd0, q[22:0]};
    endfunction

    function automatic bit sp_is_nan(input logic [31:0] a);
        return (a[30:23] == 8'hFF) && (a[22:0] != 0);
    endfunction

    function automatic bit sp_is_inf(input logic [31:0] a);
        return (a[30:23] == 8'hFF) && (a[22:0] == 0);
    endfunction

    function automatic int sp_lsb_exp(input logic [31:0] a);
        return ((a[30:23] == 0) ? 1 : int'(a[30:23])) - 150;
    endfunction

    function automatic logic [127:0] sp_mant(input logic [31:0] a);
        return {104'd0, (a[30:23] != 0), a[22:0]};
    endfunction

    function automatic logic [31:0] sp_mul(input logic [31:0] a, input logic [31:0] b);
        bit s;
        bit az, bz;
        s  = a[31] ^ b[31];
        az = (a[30:0] == 0);
        bz = (b[30:0] == 0);
        if (sp_is_nan(a) || sp_is_nan(b)) return CANON_NAN;
        if ((sp_is_inf(a) && bz) || (sp_is_inf(b) && az)) return CANON_NAN;
        if (sp_is_inf(a) || sp_is_inf(b)) return {s, 8'hFF, 23'd0};
        if (az || bz) return {s, 31'd0};
        return sp_round(s, sp_mant(a) * sp_mant(b), sp_lsb_exp(a) + sp_lsb_exp(b));
    endfunction

    function automatic logic [31:0] sp_add(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] x, y;
        logic [127:0] mx, my, tot;
        int ex, ey, d, e;
        if (sp_is_nan(a) || sp_is_nan(b)) return CANON_NAN;
        if (sp_is_inf(a) && sp_is_inf(b)) return (a[31] != b[31]) ? CANON_NAN : a;
        if (sp_is_inf(a)) return a;
        if (sp_is_inf(b)) return b;
        if (a[30:0] == 0 && b[30:0] == 0) return {a[31] & b[31], 31'd0};
        if (a[30:0] < b[30:0]) begin
            x = b; y = a;
        end else begin
            x = a; y = b;
        end
        mx = sp_mant(x);
        my = sp_mant(y);
        ex = sp_lsb_exp(x);
        ey = sp_lsb_exp(y);
        d  = ex - ey;
        // far-away addend only matters as a sticky bit
        if (d > 40) begin
            mx = mx << 42;
            my = (my != 0) ? 128'd1 : 128'd0;
            e  = ex - 42;
        end else begin
            mx = mx << d;
            e  = ey;
        end
        tot = (x[31] ^ y[31]) ? mx - my : mx + my;
        if (tot == 0) return 32'd0;
        return sp_round(x[31], tot, e);
    endfunction

    function automatic logic [31:0] nibble_to_sp(input logic [7:0] wb, input bit hi);
        logic [3:0] nib;
        int v;
        nib = hi ? wb[7:4] : wb[3:0];
        v = nib[3] ? int'(nib) - 16 : int'(nib);
        if (v == 0) return 32'd0;
        return sp_round(v < 0, 128'((v < 0) ? -v : v), 0);
    endfunction

    // Tracks the accumulator and holds the dot products still owed
    class dot_sum_tracker;
        logic [31:0] acc;
        logic [31:0] pending_sums[$];
        int checked;

        function new();
            acc = 32'd0;
            checked = 0;
        endfunction

        function void note_term(logic [31:0] act, logic [7:0] wb, bit hi,
                                logic [31:0] scale, bit last);
            logic [31:0] term;
            term = sp_mul(sp_mul(act, nibble_to_sp(wb, hi)), scale);
            acc = sp_add(acc, term);
            if (sp_is_nan(acc)) acc = CANON_NAN;
            if (last) begin
                pending_sums.push_back(acc);
                acc = 32'd0;
            end
        endfunction

        // 0: match, 1: mismatch, 2: nothing owed
        function int check_sum(logic [31:0] got, output logic [31:0] want);
            want = 32'hx;
            if (pending_sums.size() == 0) return 2;
            want = pending_sums.pop_front();
            checked++;
            return (got === want) ? 0 : 1;
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [31:0] i_activation;
    logic [7:0]  i_weight_byte;
    logic        i_high_nibble;
    logic [31:0] i_group_scale;
    logic        i_last_term;
    logic        o_valid;
    logic        i_ready;
    logic [31:0] o_dot_sum;

    int4_dequant_dot_product i_dut (.*);

    dot_sum_tracker sums = new();
    int  n_errors;
    int  n_sent;
    bit  no_idle;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d dot products still owed", sums.pending_sums.size());
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic report(input string what);
        n_errors++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // Monitor both channels at each edge
    always @(posedge i_clk) begin
        logic [31:0] want;
        int st;
        if (i_rst_n && i_valid && o_ready)
            sums.note_term(i_activation, i_weight_byte, i_high_nibble,
                           i_group_scale, i_last_term);
        if (i_rst_n && o_valid && i_ready) begin
            st = sums.check_sum(o_dot_sum, want);
            if (st == 2)
                report($sformatf("unexpected dot_sum %08h", o_dot_sum));
            else if (st == 1)
                report($sformatf("dot_sum %08h, expected %08h", o_dot_sum, want));
        end
    end

    // Result side: random stall bursts
    int stall_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready    <= 1'b0;
            stall_left <= 0;
        end else if (no_idle) begin
            i_ready <= 1'b1;
        end else if (stall_left > 0) begin
            i_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 7) == 0) begin
            i_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 15);
        end else begin
            i_ready <= 1'b1;
        end
    end

    function automatic logic [31:0] pick_float();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 15))
            0: r = {r[31], 31'd0};
            1: r = {r[31], 8'hFF, 23'd0};
            2: r = {r[31], 8'hFF, r[22:1], 1'b1};
            3: r = {r[31], 8'd0, r[22:0]};
            4: ;
            5: r = {r[31], r[0] ? 8'hFE : 8'h01, r[22:0]};
            default: r = {r[31], 8'($urandom_range(110, 140)), r[22:0]};
        endcase
        return r;
    endfunction

    // One item, with an optional idle burst first
    task automatic send_term(input logic [31:0] act, input logic [7:0] wb, input bit hi,
                             input logic [31:0] scale, input bit last);
        int gap;
        if (!no_idle && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 16);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_activation  <= act;
        i_weight_byte <= wb;
        i_high_nibble <= hi;
        i_group_scale <= scale;
        i_last_term   <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        n_sent++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sums.pending_sums.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        int len;
        n_errors = 0;
        n_sent   = 0;
        no_idle  = 1'b0;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_activation  = '0;
        i_weight_byte = '0;
        i_high_nibble = 1'b0;
        i_group_scale = '0;
        i_last_term   = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: a selection of nibble values, both halves
        send_term(32'h3F80_0000, 8'h70, 1'b1, 32'h3F80_0000, 1'b0);
        send_term(32'h3F80_0000, 8'h08, 1'b0, 32'h3F80_0000, 1'b0);
        send_term(32'hBFC0_0000, 8'hF9, 1'b1, 32'h4000_0000, 1'b0);
        send_term(32'h4120_0000, 8'h9F, 1'b0, 32'h3E80_0000, 1'b1);
        // cancellation to positive zero
        send_term(32'h4040_0000, 8'h01, 1'b0, 32'h3F80_0000, 1'b0);
        send_term(32'h4040_0000, 8'h0F, 1'b0, 32'h3F80_0000, 1'b1);
        // only negative zero terms: sum stays positive zero
        send_term(32'h8000_0000, 8'h03, 1'b0, 32'h3F80_0000, 1'b0);
        send_term(32'h3F80_0000, 8'h00, 1'b0, 32'hBF80_0000, 1'b1);
        // infinity times zero weight, and inf minus inf
        send_term(32'h7F80_0000, 8'h00, 1'b1, 32'h3F80_0000, 1'b1);
        send_term(32'h7F80_0000, 8'h01, 1'b0, 32'h3F80_0000, 1'b0);
        send_term(32'hFF80_0000, 8'h01, 1'b0, 32'h3F80_0000, 1'b1);
        // NaN payload with sign set
        send_term(32'hFFAB_CDEF, 8'h55, 1'b1, 32'h3F80_0000, 1'b1);
        // subnormal operands and underflow
        send_term(32'h0000_0001, 8'h07, 1'b0, 32'h3F00_0000, 1'b0);
        send_term(32'h007F_FFFF, 8'hE0, 1'b1, 32'h0080_0000, 1'b1);
        // overflow to infinity
        send_term(32'h7F7F_FFFF, 8'h07, 1'b0, 32'h7F7F_FFFF, 1'b1);
        send_term(32'hFFFF_FFFF, 8'hFF, 1'b1, 32'hFFFF_FFFF, 1'b1);
        send_term(32'h0000_0000, 8'h00, 1'b0, 32'h0000_0000, 1'b1);

        // Random dot products of a few terms each
        while (n_sent < 545) begin
            if (n_sent > 300 && n_sent < 310) drain();
            if (n_sent > 480) no_idle = 1'b1;
            len = $urandom_range(1, 8);
            for (int k = 1; k <= len; k++)
                send_term(pick_float(), 8'($urandom), 1'($urandom), pick_float(),
                          k == len);
        end
        drain();
        repeat (20) @(posedge i_clk);

        $display("Sent %0d terms, checked %0d dot products", n_sent, sums.checked);
        $display("Covered signed zeros, infinities, NaNs, subnormals and overflow");
        if (n_errors == 0 && sums.pending_sums.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== int4_dequant_dot_product.f =====
sv/idp_pkg.sv
sv/idp_front.sv
sv/idp_queue.sv
sv/idp_back.sv
sv/int4_dequant_dot_product.sv
tb/tb_int4_dequant_dot_product.sv
